FILE: src/stt_pkg.sv
// ----------------------------------------------------------------------------
// Source text tokenizer package
// Shared widths, scanner modes, token codes, result type and keyword lookup.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int MAX_TEXT_DEF = 63;
  localparam int BYTE_W       = 8;
  localparam int TK_W         = 6;
  localparam int LEN_W        = 6;
  localparam int VAL_W        = 32;
  localparam int WIN_W        = 48;
  localparam int ACC_W        = 63;

  localparam logic [ACC_W-1:0] NUM_MAX = '1;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_STRING,
    MODE_LINE,
    MODE_BLOCK,
    MODE_BSTAR,
    MODE_P_SLASH,
    MODE_P_SEMI,
    MODE_P_COLON,
    MODE_P_EQ,
    MODE_P_BANG,
    MODE_P_AMP,
    MODE_P_BAR,
    MODE_P_MINUS
  } mode_t;

  // Token codes
  localparam logic [TK_W-1:0] TK_END      = 6'd0;
  localparam logic [TK_W-1:0] TK_IDENT    = 6'd1;
  localparam logic [TK_W-1:0] TK_NUMBER   = 6'd2;
  localparam logic [TK_W-1:0] TK_STRING   = 6'd3;
  localparam logic [TK_W-1:0] TK_BIND     = 6'd4;
  localparam logic [TK_W-1:0] TK_BINDM    = 6'd5;
  localparam logic [TK_W-1:0] TK_FN       = 6'd6;
  localparam logic [TK_W-1:0] TK_IF       = 6'd7;
  localparam logic [TK_W-1:0] TK_WHILE    = 6'd8;
  localparam logic [TK_W-1:0] TK_DO       = 6'd9;
  localparam logic [TK_W-1:0] TK_ELSE     = 6'd10;
  localparam logic [TK_W-1:0] TK_AS       = 6'd11;
  localparam logic [TK_W-1:0] TK_WRITE    = 6'd12;
  localparam logic [TK_W-1:0] TK_TYPE     = 6'd13;
  localparam logic [TK_W-1:0] TK_ASSIGN   = 6'd14;
  localparam logic [TK_W-1:0] TK_EQEQ     = 6'd15;
  localparam logic [TK_W-1:0] TK_NE       = 6'd16;
  localparam logic [TK_W-1:0] TK_ANDAND   = 6'd17;
  localparam logic [TK_W-1:0] TK_OROR     = 6'd18;
  localparam logic [TK_W-1:0] TK_ARROW    = 6'd19;
  localparam logic [TK_W-1:0] TK_FATARROW = 6'd20;
  localparam logic [TK_W-1:0] TK_EQ       = 6'd21;
  localparam logic [TK_W-1:0] TK_AT       = 6'd22;
  localparam logic [TK_W-1:0] TK_BANG     = 6'd23;
  localparam logic [TK_W-1:0] TK_LBRACK   = 6'd24;
  localparam logic [TK_W-1:0] TK_RBRACK   = 6'd25;
  localparam logic [TK_W-1:0] TK_DOT      = 6'd26;
  localparam logic [TK_W-1:0] TK_LBRACE   = 6'd27;
  localparam logic [TK_W-1:0] TK_RBRACE   = 6'd28;
  localparam logic [TK_W-1:0] TK_LPAREN   = 6'd29;
  localparam logic [TK_W-1:0] TK_RPAREN   = 6'd30;
  localparam logic [TK_W-1:0] TK_SEMI     = 6'd31;
  localparam logic [TK_W-1:0] TK_COMMA    = 6'd32;
  localparam logic [TK_W-1:0] TK_PLUS     = 6'd33;
  localparam logic [TK_W-1:0] TK_MINUS    = 6'd34;
  localparam logic [TK_W-1:0] TK_STAR     = 6'd35;
  localparam logic [TK_W-1:0] TK_SLASH    = 6'd36;
  localparam logic [TK_W-1:0] TK_LT       = 6'd37;
  localparam logic [TK_W-1:0] TK_GT       = 6'd38;

  // Keyword spellings, first character in the most significant used byte
  localparam logic [WIN_W-1:0] W_BIND   = "bind";
  localparam logic [WIN_W-1:0] W_BINDM  = "bindm";
  localparam logic [WIN_W-1:0] W_FN     = "fn";
  localparam logic [WIN_W-1:0] W_IF     = "if";
  localparam logic [WIN_W-1:0] W_WHILE  = "while";
  localparam logic [WIN_W-1:0] W_DO     = "do";
  localparam logic [WIN_W-1:0] W_ELSE   = "else";
  localparam logic [WIN_W-1:0] W_AS     = "as";
  localparam logic [WIN_W-1:0] W_WRITE  = "write";
  localparam logic [WIN_W-1:0] W_INT    = "int";
  localparam logic [WIN_W-1:0] W_I32    = "i32";
  localparam logic [WIN_W-1:0] W_I8     = "i8";
  localparam logic [WIN_W-1:0] W_STRING = "string";
  localparam logic [WIN_W-1:0] W_STR    = "str";
  localparam logic [WIN_W-1:0] W_FLOAT  = "float";
  localparam logic [WIN_W-1:0] W_NUMBER = "number";
  localparam logic [WIN_W-1:0] W_BOOL   = "bool";
  localparam logic [WIN_W-1:0] W_ANY    = "any";

  typedef struct packed {
    logic                    kind;
    logic [BYTE_W-1:0]       text_char;
    logic [TK_W-1:0]         token_kind;
    logic [LEN_W-1:0]        text_length;
    logic signed [VAL_W-1:0] number_value;
    logic                    last;
  } res_t;

  function automatic res_t mk_token(input logic [TK_W-1:0] tk, input logic [BYTE_W-1:0] ch,
                                    input logic [LEN_W-1:0] len,
                                    input logic [VAL_W-1:0] val);
    res_t r;
    r.kind         = 1'b1;
    r.text_char    = ch;
    r.token_kind   = tk;
    r.text_length  = len;
    r.number_value = val;
    r.last         = 1'b0;
    return r;
  endfunction

  function automatic logic [TK_W-1:0] single_kind(input logic [BYTE_W-1:0] b);
    logic [TK_W-1:0] k;
    case (b)
      "@":     k = TK_AT;
      "[":     k = TK_LBRACK;
      "]":     k = TK_RBRACK;
      ".":     k = TK_DOT;
      "{":     k = TK_LBRACE;
      "}":     k = TK_RBRACE;
      "(":     k = TK_LPAREN;
      ")":     k = TK_RPAREN;
      ",":     k = TK_COMMA;
      "+":     k = TK_PLUS;
      "*":     k = TK_STAR;
      "<":     k = TK_LT;
      ">":     k = TK_GT;
      default: k = TK_END;
    endcase
    return k;
  endfunction

  // The window holds the first stored byte in its low bits and zeros above the
  // stored length. A length of seven stands for anything longer than six.
  function automatic logic [TK_W-1:0] kw_kind(input logic [WIN_W-1:0] win,
                                              input logic [2:0] len);
    logic [WIN_W-1:0] be;
    logic [WIN_W-1:0] key;
    logic [TK_W-1:0]  k;
    be  = {win[7:0], win[15:8], win[23:16], win[31:24], win[39:32], win[47:40]};
    key = be >> {3'd6 - len, 3'b000};
    if (len == 3'd0 || len == 3'd7) begin
      k = TK_IDENT;
    end else begin
      case (key)
        W_BIND:  k = TK_BIND;
        W_BINDM: k = TK_BINDM;
        W_FN:    k = TK_FN;
        W_IF:    k = TK_IF;
        W_WHILE: k = TK_WHILE;
        W_DO:    k = TK_DO;
        W_ELSE:  k = TK_ELSE;
        W_AS:    k = TK_AS;
        W_WRITE: k = TK_WRITE;
        W_INT, W_I32, W_I8, W_STRING, W_STR, W_FLOAT, W_NUMBER, W_BOOL, W_ANY:
          k = TK_TYPE;
        default: k = TK_IDENT;
      endcase
    end
    return k;
  endfunction

endpackage

FILE: src/stt_if.sv
// ----------------------------------------------------------------------------
// Tokenizer stream interfaces
// Valid/ready channels for source bytes in and tokenizer results out.
// ----------------------------------------------------------------------------
interface stt_in_if
  import stt_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte_in;

  modport source (output valid, output text_byte_in, input ready);
  modport sink   (input valid, input text_byte_in, output ready);
endinterface

interface stt_out_if
  import stt_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic [BYTE_W-1:0]       text_char;
  logic [TK_W-1:0]         token_kind;
  logic [LEN_W-1:0]        text_length;
  logic signed [VAL_W-1:0] number_value;
  logic                    last;

  modport source (output valid, output kind, output text_char, output token_kind,
                  output text_length, output number_value, output last, input ready);
  modport sink   (input valid, input kind, input text_char, input token_kind,
                  input text_length, input number_value, input last, output ready);
endinterface

FILE: src/source_text_tokenizer_core.sv
// Flow: a byte accepted into the input register is scanned and its results are
// written to the result queue when it has room; they leave one per transfer.
// Throughput: one byte per cycle while the four-entry result queue has room
// for the two results a byte can cause; one result drains per cycle with ready.
// Reset (synchronous, rst_n low) empties the queue and returns the scanner to
// idle with cleared text count, keyword window and number accumulator.
// ----------------------------------------------------------------------------
// Source text tokenizer core
// Byte-serial scanner: input register, one pass of scan logic, result queue.
// ----------------------------------------------------------------------------
module source_text_tokenizer_core
  import stt_pkg::*;
#(
  parameter int MAX_TEXT = MAX_TEXT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  stt_in_if.sink    in_chan,
  stt_out_if.source out_chan
);

  localparam int CW    = $clog2(MAX_TEXT + 1);
  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  // Input register
  logic              vld_r;
  logic [BYTE_W-1:0] byte_r;

  // Scanner state
  mode_t            mode_r, mode_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [WIN_W-1:0] window_r, window_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;

  // Result queue
  res_t            fifo_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PW:0]     fill_r;

  logic fire, pop;
  logic [1:0] n_res;
  res_t r0, r1;

  assign fire = vld_r && (fill_r <= (PW+1)'(DEPTH - 2));
  assign pop  = out_chan.valid && out_chan.ready;
  assign in_chan.ready = !vld_r || fire;

  // Start-of-token logic shared by idle and every mode that falls back to idle
  logic       id_emit, id_clear, id_store;
  res_t       id_res;
  mode_t      id_mode;
  logic [TK_W-1:0] single_k;

  always_comb begin
    id_emit  = 1'b0;
    id_clear = 1'b0;
    id_store = 1'b0;
    id_res   = '0;
    id_mode  = MODE_IDLE;
    single_k = single_kind(byte_r);
    case (byte_r) inside
      8'd0: begin
        id_emit  = 1'b1;
        id_clear = 1'b1;
        id_res   = mk_token(TK_END, '0, '0, '0);
      end
      [8'd9:8'd13], " ": ;
      ["a":"z"], ["A":"Z"], "_": begin
        id_clear = 1'b1;
        id_store = 1'b1;
        id_mode  = MODE_IDENT;
      end
      ["0":"9"]: begin
        id_clear = 1'b1;
        id_store = 1'b1;
        id_mode  = MODE_NUMBER;
      end
      "\"": begin
        id_clear = 1'b1;
        id_mode  = MODE_STRING;
      end
      "/": id_mode = MODE_P_SLASH;
      ";": id_mode = MODE_P_SEMI;
      ":": id_mode = MODE_P_COLON;
      "=": id_mode = MODE_P_EQ;
      "!": id_mode = MODE_P_BANG;
      "&": id_mode = MODE_P_AMP;
      "|": id_mode = MODE_P_BAR;
      "-": id_mode = MODE_P_MINUS;
      default: begin
        id_emit = 1'b1;
        if (single_k != TK_END) begin
          id_res = mk_token(single_k, '0, '0, '0);
        end else begin
          id_res = mk_token(TK_END, byte_r, '0, '0);
        end
      end
    endcase
  end

  // Per-mode decision: an optional completed token first, then either the
  // start-of-token logic or a stored text byte.
  logic       pre_v, run_idle, run_store;
  res_t       pre_res;
  mode_t      mode_step;
  logic       is_alnum, is_digit;
  logic [2:0] len3;
  logic [LEN_W-1:0] len_out;

  assign is_digit = (byte_r >= "0") && (byte_r <= "9");
  assign is_alnum = is_digit || ((byte_r >= "a") && (byte_r <= "z")) ||
                    ((byte_r >= "A") && (byte_r <= "Z")) || (byte_r == "_");
  assign len3     = (count_r < CW'(7)) ? count_r[2:0] : 3'd7;
  assign len_out  = LEN_W'(count_r);

  always_comb begin
    pre_v     = 1'b0;
    pre_res   = '0;
    run_idle  = 1'b0;
    run_store = 1'b0;
    mode_step = mode_r;
    case (mode_r)
      MODE_IDENT: begin
        if (is_alnum) begin
          run_store = 1'b1;
        end else begin
          pre_v    = 1'b1;
          pre_res  = mk_token(kw_kind(window_r, len3), '0, len_out, '0);
          run_idle = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (is_digit) begin
          run_store = 1'b1;
        end else begin
          pre_v    = 1'b1;
          pre_res  = mk_token(TK_NUMBER, '0, len_out, acc_r[VAL_W-1:0]);
          run_idle = 1'b1;
        end
      end
      MODE_STRING: begin
        if (byte_r == "\"") begin
          pre_v     = 1'b1;
          pre_res   = mk_token(TK_STRING, '0, len_out, '0);
          mode_step = MODE_IDLE;
        end else if (byte_r == 8'd0) begin
          pre_v    = 1'b1;
          pre_res  = mk_token(TK_STRING, '0, len_out, '0);
          run_idle = 1'b1;
        end else begin
          run_store = 1'b1;
        end
      end
      MODE_LINE: begin
        if (byte_r == 8'h0a) begin
          mode_step = MODE_IDLE;
        end else if (byte_r == 8'd0) begin
          run_idle = 1'b1;
        end
      end
      MODE_BLOCK, MODE_BSTAR: begin
        if (byte_r == 8'd0) begin
          run_idle = 1'b1;
        end else if (byte_r == "*") begin
          mode_step = MODE_BSTAR;
        end else if (byte_r == "/" && mode_r == MODE_BSTAR) begin
          mode_step = MODE_IDLE;
        end else begin
          mode_step = MODE_BLOCK;
        end
      end
      MODE_P_SLASH: begin
        if (byte_r == "/") begin
          mode_step = MODE_LINE;
        end else if (byte_r == "*") begin
          mode_step = MODE_BLOCK;
        end else begin
          pre_v    = 1'b1;
          pre_res  = mk_token(TK_SLASH, '0, '0, '0);
          run_idle = 1'b1;
        end
      end
      MODE_P_SEMI: begin
        if (byte_r == ";") begin
          mode_step = MODE_LINE;
        end else begin
          pre_v    = 1'b1;
          pre_res  = mk_token(TK_SEMI, '0, '0, '0);
          run_idle = 1'b1;
        end
      end
      MODE_P_COLON: begin
        pre_v = 1'b1;
        if (byte_r == "=") begin
          pre_res   = mk_token(TK_ASSIGN, '0, '0, '0);
          mode_step = MODE_IDLE;
        end else begin
          pre_res  = mk_token(TK_TYPE, '0, '0, '0);
          run_idle = 1'b1;
        end
      end
      MODE_P_EQ: begin
        pre_v = 1'b1;
        if (byte_r == ">") begin
          pre_res   = mk_token(TK_FATARROW, '0, '0, '0);
          mode_step = MODE_IDLE;
        end else if (byte_r == "=") begin
          pre_res   = mk_token(TK_EQEQ, '0, '0, '0);
          mode_step = MODE_IDLE;
        end else begin
          pre_res  = mk_token(TK_EQ, '0, '0, '0);
          run_idle = 1'b1;
        end
      end
      MODE_P_BANG: begin
        pre_v = 1'b1;
        if (byte_r == "=") begin
          pre_res   = mk_token(TK_NE, '0, '0, '0);
          mode_step = MODE_IDLE;
        end else begin
          pre_res  = mk_token(TK_BANG, '0, '0, '0);
          run_idle = 1'b1;
        end
      end
      MODE_P_AMP: begin
        pre_v = 1'b1;
        if (byte_r == "&") begin
          pre_res   = mk_token(TK_ANDAND, '0, '0, '0);
          mode_step = MODE_IDLE;
        end else begin
          pre_res  = mk_token(TK_END, "&", '0, '0);
          run_idle = 1'b1;
        end
      end
      MODE_P_BAR: begin
        pre_v = 1'b1;
        if (byte_r == "|") begin
          pre_res   = mk_token(TK_OROR, '0, '0, '0);
          mode_step = MODE_IDLE;
        end else begin
          pre_res  = mk_token(TK_END, "|", '0, '0);
          run_idle = 1'b1;
        end
      end
      MODE_P_MINUS: begin
        pre_v = 1'b1;
        if (byte_r == ">") begin
          pre_res   = mk_token(TK_ARROW, '0, '0, '0);
          mode_step = MODE_IDLE;
        end else begin
          pre_res  = mk_token(TK_MINUS, '0, '0, '0);
          run_idle = 1'b1;
        end
      end
      default: run_idle = 1'b1;
    endcase
  end

  // Text store and number accumulation
  logic             do_store, do_clear, num_mode, st_emit;
  logic [CW-1:0]    count_b;
  logic [WIN_W-1:0] window_b;
  logic [ACC_W-1:0] acc_b;
  logic [ACC_W+3:0] acc_sum;
  res_t             st_res;
  logic             second_v;
  res_t             second_res;

  always_comb begin
    do_store = run_store || (run_idle && id_store);
    do_clear = run_idle && id_clear;
    num_mode = run_idle ? (id_mode == MODE_NUMBER) : (mode_r == MODE_NUMBER);
    mode_nxt = run_idle ? id_mode : mode_step;

    count_b  = do_clear ? '0 : count_r;
    window_b = do_clear ? '0 : window_r;
    acc_b    = do_clear ? '0 : acc_r;

    st_emit  = do_store && (count_b < CW'(MAX_TEXT));
    acc_sum  = {acc_b, 3'b000} + {2'b00, acc_b, 1'b0} + (ACC_W+4)'(byte_r - "0");

    count_nxt  = count_b;
    window_nxt = window_b;
    acc_nxt    = acc_b;
    if (st_emit) begin
      count_nxt = count_b + CW'(1);
      for (int i = 0; i < 6; i++) begin
        if (count_b == CW'(i)) begin
          window_nxt[8*i +: 8] = byte_r;
        end
      end
      if (num_mode) begin
        // Saturates like strtoll once the value passes the largest positive
        acc_nxt = (acc_sum > (ACC_W+4)'(NUM_MAX)) ? NUM_MAX : acc_sum[ACC_W-1:0];
      end
    end

    st_res           = '0;
    st_res.text_char = byte_r;

    second_v   = st_emit || (run_idle && id_emit);
    second_res = st_emit ? st_res : id_res;

    n_res   = 2'(pre_v) + 2'(second_v);
    r0      = pre_v ? pre_res : second_res;
    r0.last = !(pre_v && second_v);
    r1      = second_res;
    r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= 1'b0;
      mode_r   <= MODE_IDLE;
      count_r  <= '0;
      window_r <= '0;
      acc_r    <= '0;
    end else begin
      if (in_chan.ready) begin
        vld_r <= in_chan.valid;
      end
      if (fire) begin
        mode_r   <= mode_nxt;
        count_r  <= count_nxt;
        window_r <= window_nxt;
        acc_r    <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      byte_r <= in_chan.text_byte_in;
    end
  end

  // Result queue: up to two writes per byte, one read per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (fire) begin
        wr_ptr_r <= wr_ptr_r + PW'(n_res);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      fill_r <= fill_r + (fire ? (PW+1)'(n_res) : '0) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (fire && n_res != 2'd0) begin
      fifo_r[wr_ptr_r] <= r0;
    end
    if (fire && n_res == 2'd2) begin
      fifo_r[wr_ptr_r + PW'(1)] <= r1;
    end
  end

  assign out_chan.valid        = (fill_r != '0);
  assign out_chan.kind         = fifo_r[rd_ptr_r].kind;
  assign out_chan.text_char    = fifo_r[rd_ptr_r].text_char;
  assign out_chan.token_kind   = fifo_r[rd_ptr_r].token_kind;
  assign out_chan.text_length  = fifo_r[rd_ptr_r].text_length;
  assign out_chan.number_value = fifo_r[rd_ptr_r].number_value;
  assign out_chan.last         = fifo_r[rd_ptr_r].last;

endmodule

FILE: src/stt_checker.sv
// ----------------------------------------------------------------------------
// Tokenizer port checker
// Concurrent checks on the result channel, bound to the tokenizer core.
// ----------------------------------------------------------------------------
module stt_checker
  import stt_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic                    out_kind,
  input logic [BYTE_W-1:0]       out_text_char,
  input logic [TK_W-1:0]         out_token_kind,
  input logic [LEN_W-1:0]        out_text_length,
  input logic signed [VAL_W-1:0] out_number_value,
  input logic                    out_last
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  // A text byte is always the final result of its input byte.
  a_text_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_kind |-> out_last && out_token_kind == TK_END &&
                               out_text_length == '0)
    else $error("text byte result malformed");

  // Only unknown tokens carry a character in a completed token.
  a_tok_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind && out_token_kind != TK_END |-> out_text_char == '0)
    else $error("completed token carries a character");

  // A value appears on number tokens only.
  a_num_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_number_value != '0 |-> out_kind && out_token_kind == TK_NUMBER)
    else $error("number value on a non-number result");

endmodule

bind source_text_tokenizer_core stt_checker u_stt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_kind         (out_chan.kind),
  .out_text_char    (out_chan.text_char),
  .out_token_kind   (out_chan.token_kind),
  .out_text_length  (out_chan.text_length),
  .out_number_value (out_chan.number_value),
  .out_last         (out_chan.last)
);
